// ===== design/spbi_pkg.sv =====
// Shared constants, codes and control types of the sample playback interpolator.
package spbi_pkg;

	localparam int unsigned MAX_FRAMES_DEF  = 65536;
	localparam int unsigned SAMPLE_BITS_DEF = 16;

	localparam int unsigned ADDR_W    = 16;
	localparam int unsigned STEP_W    = 19;
	localparam int unsigned GAIN_W    = 16;
	localparam int unsigned FC_W      = 17;
	localparam int unsigned POS_W     = 34;
	localparam int unsigned FRAC_W    = 16;
	localparam int unsigned INT_W     = POS_W - FRAC_W;
	localparam int unsigned GAIN_FRAC = 14;
	localparam int unsigned MULT_W    = (FRAC_W > GAIN_W) ? FRAC_W : GAIN_W;

	localparam int unsigned APB_AW = 4;
	localparam int unsigned APB_DW = 32;

	localparam logic [STEP_W-1:0] STEP_RST = STEP_W'(65536);
	localparam logic [GAIN_W-1:0] GAIN_RST = GAIN_W'(16384);
	localparam logic              LOOP_RST = 1'b1;
	localparam logic [FC_W-1:0]   FC_RST   = '0;

	typedef enum logic [1:0] {
		ACT_WRITE     = 2'd0,
		ACT_TICK      = 2'd1,
		ACT_TRANSPORT = 2'd2
	} action_t;

	typedef enum logic [1:0] {
		REG_STEP   = 2'd0,
		REG_GAIN   = 2'd1,
		REG_LOOP   = 2'd2,
		REG_FRAMES = 2'd3
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_WRAP,
		ST_LOOKUP_A,
		ST_LOOKUP_B,
		ST_LOAD,
		ST_MIX,
		ST_LOAD_GAIN,
		ST_GAIN,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic load_mix;
		logic load_gain;
		logic shift;
	} mac_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} wrap_sts_t;

endpackage

// ===== design/spbi_cmd_if.sv =====
// Command channel: frame writes, ticks and transport items.
interface spbi_cmd_if import spbi_pkg::*; #(
	parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) ();
	logic                          valid;
	logic                          ready;
	logic [1:0]                    action;
	logic [ADDR_W-1:0]             frame_address;
	logic signed [SAMPLE_BITS-1:0] left_sample;
	logic signed [SAMPLE_BITS-1:0] right_sample;
	logic                          play_flag;
	logic                          rewind_flag;

	modport source (
		output valid, action, frame_address, left_sample, right_sample, play_flag,
			rewind_flag,
		input ready
	);
	modport sink (
		input valid, action, frame_address, left_sample, right_sample, play_flag,
			rewind_flag,
		output ready
	);
endinterface

// ===== design/spbi_audio_if.sv =====
// Audio channel: one stereo output frame per tick.
interface spbi_audio_if import spbi_pkg::*; #(
	parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) ();
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] left_out;
	logic signed [SAMPLE_BITS-1:0] right_out;
	logic                          active;

	modport source (output valid, left_out, right_out, active, input ready);
	modport sink (input valid, left_out, right_out, active, output ready);
endinterface

// ===== design/spbi_store.sv =====
// Stereo sample memory: one write port, one registered read port.
module spbi_store import spbi_pkg::*; #(
	parameter int unsigned DEPTH  = MAX_FRAMES_DEF,
	parameter int unsigned DATA_W = 2 * SAMPLE_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [DATA_W-1:0]        wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [DATA_W-1:0]        rd_data
);
	logic [DATA_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end
endmodule

// ===== design/spbi_mac.sv =====
// Bit-serial blend and gain lane for one channel, one multiplier bit per cycle.
module spbi_mac import spbi_pkg::*; #(
	parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                          clk,
	input  mac_ctl_t                      ctl,
	input  logic signed [SAMPLE_BITS-1:0] near_smp,
	input  logic signed [SAMPLE_BITS-1:0] far_smp,
	input  logic [FRAC_W-1:0]             frac,
	input  logic [GAIN_W-1:0]             gain,
	output logic signed [SAMPLE_BITS-1:0] result
);
	localparam int unsigned ACC_W = SAMPLE_BITS + MULT_W + 3;
	localparam int unsigned DIF_W = SAMPLE_BITS + 1;
	localparam logic signed [ACC_W-1:0] MIX_HALF  = ACC_W'(1) << (FRAC_W - 1);
	localparam logic signed [ACC_W-1:0] GAIN_HALF = ACC_W'(1) << (GAIN_FRAC - 1);
	localparam logic signed [ACC_W-1:0] SMP_MAX   = (ACC_W'(1) << (SAMPLE_BITS - 1)) - ACC_W'(1);
	localparam logic signed [ACC_W-1:0] SMP_MIN   = ~SMP_MAX;

	logic signed [ACC_W-1:0] acc_q;
	logic signed [ACC_W-1:0] mcand_q;
	logic [MULT_W-1:0]       mult_q;
	logic signed [DIF_W-1:0] diff;
	logic signed [ACC_W-1:0] scaled;

	assign diff = DIF_W'(far_smp) - DIF_W'(near_smp);

	always_ff @(posedge clk) begin
		if (ctl.load_mix) begin
			acc_q   <= (ACC_W'(near_smp) <<< FRAC_W) + MIX_HALF;
			mcand_q <= ACC_W'(diff);
			mult_q  <= MULT_W'(frac);
		end else if (ctl.load_gain) begin
			// floor of the blend sum is the interpolated sample
			mcand_q <= acc_q >>> FRAC_W;
			acc_q   <= GAIN_HALF;
			mult_q  <= MULT_W'(gain);
		end else if (ctl.shift) begin
			if (mult_q[0]) begin
				acc_q <= acc_q + mcand_q;
			end
			mcand_q <= mcand_q <<< 1;
			mult_q  <= mult_q >> 1;
		end
	end

	always_comb begin
		scaled = acc_q >>> GAIN_FRAC;
		if (scaled > SMP_MAX) begin
			result = SAMPLE_BITS'(SMP_MAX);
		end else if (scaled < SMP_MIN) begin
			result = SAMPLE_BITS'(SMP_MIN);
		end else begin
			result = SAMPLE_BITS'(scaled);
		end
	end
endmodule

// ===== design/spbi_wrap.sv =====
// Restoring remainder of the frame index by the length, one quotient bit per cycle.
module spbi_wrap import spbi_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [INT_W-1:0] numer,
	input  logic [FC_W-1:0]  denom,
	output wrap_sts_t        sts,
	output logic [INT_W-1:0] rem
);
	localparam int unsigned CNT_W = $clog2(INT_W);

	logic [INT_W-1:0] numer_q;
	logic [FC_W-1:0]  rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [FC_W:0]    trial;
	logic [FC_W:0]    trial_sub;

	assign trial     = {rem_q, numer_q[INT_W-1]};
	assign trial_sub = trial - {1'b0, denom};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(INT_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			numer_q <= numer;
			rem_q   <= '0;
		end else if (busy_q) begin
			numer_q <= numer_q << 1;
			// keep the partial remainder below the divisor
			if (trial >= {1'b0, denom}) begin
				rem_q <= trial_sub[FC_W-1:0];
			end else begin
				rem_q <= trial[FC_W-1:0];
			end
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign rem      = INT_W'(rem_q);
endmodule

// ===== design/sample_playback_interpolator_unit.sv =====
// Top level: stereo sample playback with linear interpolation and gain.
//
//  channel  | kind         | carries
//  ---------+--------------+------------------------------------------------
//  cmd      | sink         | action, frame_address, left/right_sample, flags
//  audio    | source       | left_out, right_out, active
//  apb      | register bus | step_ratio, gain_level, loop_enable, frame_count
//
// A write or transport item leaves the block ready again at once.
// A tick makes two memory reads on the single read port, then runs the bit-serial
// blend and then the bit-serial gain. A wrap at the end of the data first runs the
// serial remainder unit. A silent tick skips the reads and the arithmetic. The audio
// register holds a result until taken; a tick that finishes while it is full waits
// in the last step. Reset clears the sequencer, position, playing flag and registers;
// no clearing pass.
module sample_playback_interpolator_unit import spbi_pkg::*; #(
	parameter int unsigned MAX_FRAMES  = MAX_FRAMES_DEF,
	parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	spbi_cmd_if.sink          cmd,
	spbi_audio_if.source      audio,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready
);
	localparam int unsigned IW      = $clog2(MAX_FRAMES);
	localparam int unsigned DATA_W  = 2 * SAMPLE_BITS;
	localparam int unsigned CNT_W   = $clog2(MULT_W);
	localparam int unsigned FC_MAX  = (1 << FC_W) - 1;
	localparam int unsigned LEN_CAP = (MAX_FRAMES < FC_MAX) ? MAX_FRAMES : FC_MAX;

	logic [STEP_W-1:0] step_q;
	logic [GAIN_W-1:0] gain_q;
	logic              loop_q;
	logic [FC_W-1:0]   fc_q;

	logic [POS_W-1:0]  pos_q;
	logic              playing_q;
	logic              silent_q;
	state_t            state_q, state_d;
	logic [CNT_W-1:0]  cnt_q;
	logic [DATA_W-1:0] near_q;

	logic                          out_valid_q;
	logic signed [SAMPLE_BITS-1:0] left_q, right_q;
	logic                          active_q;

	logic              cmd_accept;
	logic              cfg_write;
	logic [FC_W-1:0]   len;
	logic [INT_W-1:0]  pos_int;
	logic [INT_W-1:0]  pos_inc;
	logic [INT_W-1:0]  nxt;
	logic              past_end;
	logic              silent;
	logic              cnt_last;
	logic              out_free;

	logic              wr_en;
	logic              rd_en;
	logic [IW-1:0]     rd_addr;
	logic [DATA_W-1:0] rd_data;
	mac_ctl_t          mac_ctl;
	logic              wrap_start;
	wrap_sts_t         wrap_sts;
	logic [INT_W-1:0]  wrap_rem;
	logic signed [SAMPLE_BITS-1:0] left_mix, right_mix;

	assign cmd_accept = cmd.valid && cmd.ready;
	assign cfg_write  = psel && penable && pwrite && pready;
	assign pready     = 1'b1;

	// register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_RST;
			gain_q <= GAIN_RST;
			loop_q <= LOOP_RST;
			fc_q   <= FC_RST;
		end else if (cfg_write) begin
			unique case (reg_idx_t'(paddr[3:2]))
				REG_STEP:   step_q <= pwdata[STEP_W-1:0];
				REG_GAIN:   gain_q <= pwdata[GAIN_W-1:0];
				REG_LOOP:   loop_q <= pwdata[0];
				REG_FRAMES: fc_q   <= pwdata[FC_W-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx_t'(paddr[3:2]))
			REG_STEP:   prdata = APB_DW'(step_q);
			REG_GAIN:   prdata = APB_DW'(gain_q);
			REG_LOOP:   prdata = APB_DW'(loop_q);
			REG_FRAMES: prdata = APB_DW'(fc_q);
		endcase
	end

	// position decode
	always_comb begin
		len      = (fc_q > FC_W'(LEN_CAP)) ? FC_W'(LEN_CAP) : fc_q;
		pos_int  = pos_q[POS_W-1:FRAC_W];
		pos_inc  = pos_int + INT_W'(1);
		past_end = pos_int >= INT_W'(len);
		silent   = (len == '0) || !playing_q || (past_end && !loop_q);
		// last frame pairs with frame zero only when looping
		if (pos_inc < INT_W'(len)) begin
			nxt = pos_inc;
		end else if (loop_q) begin
			nxt = '0;
		end else begin
			nxt = pos_int;
		end
	end

	assign cnt_last = cnt_q == CNT_W'(MULT_W - 1);
	assign out_free = !out_valid_q || audio.ready;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_accept && cmd.action == ACT_TICK) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (silent) begin
					state_d = ST_FINISH;
				end else if (past_end) begin
					state_d = ST_WRAP;
				end else begin
					state_d = ST_LOOKUP_A;
				end
			end
			ST_WRAP: begin
				if (wrap_sts.done) begin
					state_d = ST_LOOKUP_A;
				end
			end
			ST_LOOKUP_A:  state_d = ST_LOOKUP_B;
			ST_LOOKUP_B:  state_d = ST_LOAD;
			ST_LOAD:      state_d = ST_MIX;
			ST_MIX: begin
				if (cnt_last) begin
					state_d = ST_LOAD_GAIN;
				end
			end
			ST_LOAD_GAIN: state_d = ST_GAIN;
			ST_GAIN: begin
				if (cnt_last) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default:      state_d = ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		cmd.ready         = 1'b0;
		wrap_start        = 1'b0;
		rd_en             = 1'b0;
		rd_addr           = IW'(pos_int);
		mac_ctl.load_mix  = 1'b0;
		mac_ctl.load_gain = 1'b0;
		mac_ctl.shift     = 1'b0;
		unique case (state_q)
			ST_IDLE:      cmd.ready = 1'b1;
			ST_CHECK:     wrap_start = past_end && !silent;
			ST_LOOKUP_A:  rd_en = 1'b1;
			ST_LOOKUP_B: begin
				rd_en   = 1'b1;
				rd_addr = IW'(nxt);
			end
			ST_LOAD:      mac_ctl.load_mix = 1'b1;
			ST_MIX:       mac_ctl.shift = 1'b1;
			ST_LOAD_GAIN: mac_ctl.load_gain = 1'b1;
			ST_GAIN:      mac_ctl.shift = 1'b1;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			pos_q     <= '0;
			playing_q <= 1'b0;
			cnt_q     <= '0;
		end else begin
			state_q <= state_d;
			if (cmd_accept && cmd.action == ACT_TRANSPORT) begin
				if (cmd.rewind_flag) begin
					pos_q <= '0;
				end
				playing_q <= cmd.play_flag;
			end
			if (state_q == ST_WRAP && wrap_sts.done) begin
				pos_q[POS_W-1:FRAC_W] <= wrap_rem;
			end
			// advance once both frames have been fetched
			if (state_q == ST_LOAD) begin
				pos_q <= pos_q + POS_W'(step_q);
			end
			if (mac_ctl.shift) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else begin
				cnt_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_CHECK) begin
			silent_q <= silent;
		end
		if (state_q == ST_LOOKUP_B) begin
			near_q <= rd_data;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_FINISH && out_free) begin
			out_valid_q <= 1'b1;
		end else if (audio.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FINISH && out_free) begin
			left_q   <= silent_q ? '0 : left_mix;
			right_q  <= silent_q ? '0 : right_mix;
			active_q <= !silent_q;
		end
	end

	assign audio.valid     = out_valid_q;
	assign audio.left_out  = left_q;
	assign audio.right_out = right_q;
	assign audio.active    = active_q;

	assign wr_en = cmd_accept && cmd.action == ACT_WRITE &&
		(32'(cmd.frame_address) < 32'(MAX_FRAMES));

	spbi_store #(
		.DEPTH  (MAX_FRAMES),
		.DATA_W (DATA_W)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (IW'(cmd.frame_address)),
		.wr_data ({cmd.left_sample, cmd.right_sample}),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	spbi_wrap u_wrap (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (wrap_start),
		.numer  (pos_int),
		.denom  (len),
		.sts    (wrap_sts),
		.rem    (wrap_rem)
	);

	spbi_mac #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_mac_left (
		.clk      (clk),
		.ctl      (mac_ctl),
		.near_smp ($signed(near_q[DATA_W-1:SAMPLE_BITS])),
		.far_smp  ($signed(rd_data[DATA_W-1:SAMPLE_BITS])),
		.frac     (pos_q[FRAC_W-1:0]),
		.gain     (gain_q),
		.result   (left_mix)
	);

	spbi_mac #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_mac_right (
		.clk      (clk),
		.ctl      (mac_ctl),
		.near_smp ($signed(near_q[SAMPLE_BITS-1:0])),
		.far_smp  ($signed(rd_data[SAMPLE_BITS-1:0])),
		.frac     (pos_q[FRAC_W-1:0]),
		.gain     (gain_q),
		.result   (right_mix)
	);
endmodule

// ===== design/spbi_checker.sv =====
// Port-level checks of the sample playback interpolator, bound to the top level.
module spbi_checker import spbi_pkg::*; #(
	parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          cmd_valid,
	input logic                          cmd_ready,
	input logic [1:0]                    cmd_action,
	input logic                          audio_valid,
	input logic                          audio_ready,
	input logic signed [SAMPLE_BITS-1:0] left_out,
	input logic signed [SAMPLE_BITS-1:0] right_out,
	input logic                          active
);
	// a silent frame carries zero samples
	silent_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		audio_valid && !active |-> left_out == '0 && right_out == '0)
		else $error("silent output frame carries nonzero samples");

	// a tick occupies the block
	tick_holds_off: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready && cmd_action == ACT_TICK |=> !cmd_ready)
		else $error("ready stayed high after a tick item");

	// writes, transport and unknown items finish in their own cycle
	other_item_quick: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready && cmd_action != ACT_TICK |=> cmd_ready)
		else $error("ready dropped after a non-tick item");

	audio_hold: assert property (@(posedge clk) disable iff (!arst_n)
		audio_valid && !audio_ready |=>
			audio_valid && $stable(left_out) && $stable(right_out) && $stable(active))
		else $error("stalled audio item changed");
endmodule

bind sample_playback_interpolator_unit spbi_checker #(
	.SAMPLE_BITS (SAMPLE_BITS)
) u_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.cmd_valid   (cmd.valid),
	.cmd_ready   (cmd.ready),
	.cmd_action  (cmd.action),
	.audio_valid (audio.valid),
	.audio_ready (audio.ready),
	.left_out    (audio.left_out),
	.right_out   (audio.right_out),
	.active      (audio.active)
);

// ===== verif/tb.sv =====
// Self-checking testbench for the sample playback interpolator: predicts and checks every audio item.
module tb;
	import spbi_pkg::*;

	localparam int unsigned SB         = SAMPLE_BITS_DEF;
	localparam int unsigned FRAMES_MAX = MAX_FRAMES_DEF;
	localparam logic [1:0]  ACT_UNUSED = 2'd3;
	localparam int unsigned SETTLE     = 64;
	localparam int unsigned HOLD_LEN   = 400;
	localparam int unsigned IDLE_LIMIT = 4000;
	localparam longint      S_MAXV     = (longint'(1) <<< (SB - 1)) - 1;
	localparam longint      S_MINV     = -S_MAXV - 1;

	typedef logic signed [SB-1:0] sample_t;

	localparam sample_t S_HI = {1'b0, {(SB-1){1'b1}}};
	localparam sample_t S_LO = {1'b1, {(SB-1){1'b0}}};

	typedef struct {
		logic [1:0]        action;
		logic [ADDR_W-1:0] addr;
		sample_t           left;
		sample_t           right;
		logic              play;
		logic              rewind;
	} cmd_item_t;

	typedef struct {
		sample_t left;
		sample_t right;
		logic    active;
	} stereo_out_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	spbi_cmd_if   cmd_ch ();
	spbi_audio_if audio_ch ();

	sample_playback_interpolator_unit u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd_ch),
		.audio   (audio_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// predicted block state
	sample_t           mem_left  [FRAMES_MAX];
	sample_t           mem_right [FRAMES_MAX];
	bit                mem_valid [FRAMES_MAX];
	logic [POS_W-1:0]  play_pos   = '0;
	logic              is_playing = 1'b0;
	logic [STEP_W-1:0] r_step     = STEP_RST;
	logic [GAIN_W-1:0] r_gain     = GAIN_RST;
	logic              r_loop     = LOOP_RST;
	logic [FC_W-1:0]   r_frames   = FC_RST;

	stereo_out_t expected_audio [$];
	int unsigned fail_count  = 0;
	int unsigned idle_cycles = 0;
	bit          no_gaps     = 1'b0;
	bit          hold_req    = 1'b0;

	always #5 clk = ~clk;

	// Resolve the read position for the next tick; returns 0 when the tick is silent.
	function automatic bit locate_frames(output logic [POS_W-1:0] pos, output int unsigned ia,
			output int unsigned ib);
		longint unsigned len;
		longint unsigned end_pos;
		pos = play_pos;
		ia = 0;
		ib = 0;
		len = (r_frames > FRAMES_MAX) ? FRAMES_MAX : r_frames;
		if (len == 0 || !is_playing)
			return 0;
		end_pos = len << FRAC_W;
		if (pos >= end_pos) begin
			if (!r_loop)
				return 0;
			pos = POS_W'(pos - end_pos);
			if (pos >= end_pos)
				pos = POS_W'(pos % end_pos);
		end
		ia = pos[POS_W-1:FRAC_W];
		ib = (ia + 1 < len) ? ia + 1 : (r_loop ? 0 : ia);
		return 1;
	endfunction

	function automatic sample_t mix_sample(sample_t a, sample_t b, logic [FRAC_W-1:0] frac);
		longint sa;
		longint sb;
		longint f;
		longint g;
		longint m;
		longint x;
		sa = a;
		sb = b;
		f = frac;
		g = r_gain;
		// round half up on both stages: add half, then floor
		m = (sa * 65536 + (sb - sa) * f + 32768) >>> FRAC_W;
		x = (m * g + 8192) >>> GAIN_FRAC;
		if (x > S_MAXV)
			x = S_MAXV;
		else if (x < S_MINV)
			x = S_MINV;
		return sample_t'(x);
	endfunction

	function automatic void advance_playback(cmd_item_t it);
		logic [POS_W-1:0] pos;
		int unsigned      ia;
		int unsigned      ib;
		stereo_out_t      res;
		case (it.action)
		ACT_WRITE: begin
			mem_left[it.addr] = it.left;
			mem_right[it.addr] = it.right;
			mem_valid[it.addr] = 1'b1;
		end
		ACT_TRANSPORT: begin
			if (it.rewind)
				play_pos = '0;
			is_playing = it.play;
		end
		ACT_TICK: begin
			res.left = '0;
			res.right = '0;
			res.active = 1'b0;
			if (locate_frames(pos, ia, ib)) begin
				res.left = mix_sample(mem_left[ia], mem_left[ib], pos[FRAC_W-1:0]);
				res.right = mix_sample(mem_right[ia], mem_right[ib], pos[FRAC_W-1:0]);
				res.active = 1'b1;
				play_pos = pos + POS_W'(r_step);
			end
			expected_audio = {expected_audio, res};
		end
		default: ;
		endcase
	endfunction

	function automatic cmd_item_t random_item(logic [1:0] act);
		cmd_item_t it;
		it.action = act;
		it.addr = ADDR_W'($urandom);
		it.left = sample_t'($urandom);
		it.right = sample_t'($urandom);
		it.play = 1'($urandom);
		it.rewind = 1'($urandom);
		return it;
	endfunction

	function automatic sample_t pick_sample();
		case ($urandom_range(0, 7))
		0: return S_HI;
		1: return S_LO;
		2: return '0;
		default: return sample_t'($urandom);
		endcase
	endfunction

	function automatic logic [STEP_W-1:0] pick_step();
		case ($urandom_range(0, 7))
		0: return '0;
		1: return STEP_W'(262144);
		2: return '1;
		3: return STEP_W'($urandom_range(1, 65535));
		default: return STEP_W'($urandom_range(1, 262144));
		endcase
	endfunction

	function automatic logic [GAIN_W-1:0] pick_gain();
		case ($urandom_range(0, 7))
		0: return '0;
		1: return GAIN_W'(32768);
		2: return '1;
		3: return GAIN_RST;
		default: return GAIN_W'($urandom_range(0, 32768));
		endcase
	endfunction

	function automatic logic [FC_W-1:0] pick_frames();
		case ($urandom_range(0, 9))
		0: return '0;
		1: return FC_W'(FRAMES_MAX);
		2: return '1;
		3: return FC_W'($urandom_range(1, 3));
		default: return FC_W'($urandom_range(4, 40));
		endcase
	endfunction

	function automatic void check_field(string name, logic signed [31:0] want,
			logic signed [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endfunction

	// Entered and left at a rising edge; the item is accepted at the edge on return.
	task automatic send_item(cmd_item_t it);
		int unsigned gap;
		gap = no_gaps ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.action <= it.action;
		cmd_ch.frame_address <= it.addr;
		cmd_ch.left_sample <= it.left;
		cmd_ch.right_sample <= it.right;
		cmd_ch.play_flag <= it.play;
		cmd_ch.rewind_flag <= it.rewind;
		do @(negedge clk); while (!cmd_ch.ready);
		@(posedge clk);
		advance_playback(it);
	endtask

	task automatic send_write(logic [ADDR_W-1:0] addr, sample_t l, sample_t r);
		cmd_item_t it;
		it = random_item(ACT_WRITE);
		it.addr = addr;
		it.left = l;
		it.right = r;
		send_item(it);
	endtask

	task automatic send_transport(logic play, logic rewind);
		cmd_item_t it;
		it = random_item(ACT_TRANSPORT);
		it.play = play;
		it.rewind = rewind;
		send_item(it);
	endtask

	// Fill any frame the tick would read that holds no data yet, then tick.
	task automatic send_tick();
		logic [POS_W-1:0] pos;
		int unsigned      ia;
		int unsigned      ib;
		if (locate_frames(pos, ia, ib)) begin
			if (!mem_valid[ia])
				send_write(ADDR_W'(ia), pick_sample(), pick_sample());
			if (!mem_valid[ib])
				send_write(ADDR_W'(ib), pick_sample(), pick_sample());
		end
		send_item(random_item(ACT_TICK));
	endtask

	// Hold the command channel until every audio item is back and the block has settled.
	task automatic drain();
		cmd_ch.valid <= 1'b0;
		while (expected_audio.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic reg_write(reg_idx_t idx, logic [APB_DW-1:0] value);
		logic [APB_DW-1:0] kept;
		logic [APB_DW-1:0] rd;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(negedge clk); while (!pready);
		@(posedge clk);
		case (idx)
		REG_STEP: begin
			r_step = value[STEP_W-1:0];
			kept = APB_DW'(r_step);
		end
		REG_GAIN: begin
			r_gain = value[GAIN_W-1:0];
			kept = APB_DW'(r_gain);
		end
		REG_LOOP: begin
			r_loop = value[0];
			kept = APB_DW'(r_loop);
		end
		default: begin
			r_frames = value[FC_W-1:0];
			kept = APB_DW'(r_frames);
		end
		endcase
		// read the register back
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(negedge clk); while (!pready);
		rd = prdata;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		// leave the bus idle before the next transfer
		@(posedge clk);
		if (rd !== kept) begin
			$error("prdata at 0x%0h: expected 0x%0h, got 0x%0h", {idx, 2'b00}, kept, rd);
			fail_count++;
		end
	endtask

	task automatic set_registers(logic [STEP_W-1:0] step, logic [GAIN_W-1:0] gain, logic loop_on,
			logic [FC_W-1:0] frames);
		drain();
		reg_write(REG_STEP, APB_DW'(step));
		reg_write(REG_GAIN, APB_DW'(gain));
		reg_write(REG_LOOP, APB_DW'(loop_on));
		reg_write(REG_FRAMES, APB_DW'(frames));
	endtask

	task automatic test_directed();
		// silent while frame_count is still at reset
		send_transport(1'b1, 1'b1);
		send_tick();
		send_write(0, S_HI, S_LO);
		send_write(1, S_LO, S_HI);
		send_write(2, '0, '1);
		send_write(3, sample_t'(16'h5555), sample_t'(16'hAAAA));
		send_write('1, '1, '0);
		// ratio 1.5 at gain 2.0: blends, saturation, last frame toward frame 0, wrap
		set_registers(STEP_W'(19'h18000), GAIN_W'(32768), 1'b1, FC_W'(4));
		repeat (6) send_tick();
		send_item(random_item(ACT_UNUSED));
		// stopped: silent
		send_transport(1'b0, 1'b0);
		send_tick();
		// loop off: last frame blends with itself, then silence past the end
		set_registers(STEP_W'(19'h1C000), GAIN_RST, 1'b0, FC_W'(4));
		send_transport(1'b1, 1'b1);
		repeat (4) send_tick();
		// position far past a one-frame length needs a full remainder
		set_registers('0, '1, 1'b1, FC_W'(1));
		repeat (2) send_tick();
	endtask

	task automatic test_random_playback();
		int unsigned sel;
		int unsigned span;
		for (int phase = 0; phase < 11; phase++) begin
			no_gaps = (phase % 4 == 3);
			set_registers(pick_step(), pick_gain(), $urandom_range(0, 2) != 0, pick_frames());
			span = (r_frames > 60) ? 64 : r_frames + 2;
			send_transport(1'b1, 1'($urandom_range(0, 1)));
			repeat (90) begin
				sel = $urandom_range(0, 99);
				if (sel < 68)
					send_tick();
				else if (sel < 84)
					send_write(ADDR_W'($urandom_range(0, span)), pick_sample(), pick_sample());
				else if (sel < 88)
					send_write(ADDR_W'($urandom), pick_sample(), pick_sample());
				else if (sel < 97)
					send_transport($urandom_range(0, 4) != 0, 1'($urandom_range(0, 1)));
				else
					send_item(random_item(ACT_UNUSED));
			end
		end
		no_gaps = 1'b0;
	endtask

	task automatic test_backpressure();
		set_registers(STEP_W'($urandom_range(1, 262144)), GAIN_RST, 1'b1, FC_W'(16));
		send_transport(1'b1, 1'b1);
		// stall the audio side long enough for the block to back up into the command side
		hold_req = 1'b1;
		repeat (40) send_tick();
		drain();
		repeat (20) send_tick();
	endtask

	// audio side: random stalls, one long hold on request, compare each item
	initial begin
		int unsigned stall;
		stereo_out_t got;
		stereo_out_t want;
		audio_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = no_gaps ? 0 : $urandom_range(0, 5);
			if (hold_req) begin
				hold_req = 1'b0;
				stall = HOLD_LEN;
			end
			if (stall > 0) begin
				audio_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			audio_ch.ready <= 1'b1;
			do @(negedge clk); while (!audio_ch.valid);
			got.left = audio_ch.left_out;
			got.right = audio_ch.right_out;
			got.active = audio_ch.active;
			@(posedge clk);
			if (expected_audio.size() == 0) begin
				$error("unexpected audio item: left_out %0d, right_out %0d, active %0b",
					got.left, got.right, got.active);
				fail_count++;
			end else begin
				want = expected_audio.pop_front();
				check_field("left_out", want.left, got.left);
				check_field("right_out", want.right, got.right);
				check_field("active", want.active, got.active);
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n !== 1'b1 || (cmd_ch.valid && cmd_ch.ready) ||
				(audio_ch.valid && audio_ch.ready) || psel)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		cmd_ch.valid <= 1'b0;
		cmd_ch.action <= '0;
		cmd_ch.frame_address <= '0;
		cmd_ch.left_sample <= '0;
		cmd_ch.right_sample <= '0;
		cmd_ch.play_flag <= 1'b0;
		cmd_ch.rewind_flag <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_playback();
		test_backpressure();
		drain();
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
